// File: hw/rtl/pixel_point_function_unit_core_defines.svh
// Assertion macros for the point-function unit checker.
`ifndef PIXEL_POINT_FUNCTION_UNIT_CORE_DEFINES_SVH
`define PIXEL_POINT_FUNCTION_UNIT_CORE_DEFINES_SVH

// Same-cycle implication, off while reset is held.
`define PPFU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is held.
`define PPFU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also runs through reset.
`define PPFU_ASSERT_RESET(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/ppfu_pkg.sv
// Shared constants and types for the pixel point-function unit.
package ppfu_pkg;

  localparam int SAMPLE_BITS    = 16;
  localparam int FIELD_BITS     = 16;
  localparam int TDATA_BITS     = ((FIELD_BITS + 7) / 8) * 8;
  localparam int MODE_BITS      = 4;
  localparam int GAIN_BITS      = 32;
  localparam int FRAC_BITS      = 16;
  localparam int OFFSET_BITS    = 17;
  localparam int SHIFT_BITS     = 5;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 32;
  localparam int PROD_BITS      = FIELD_BITS + GAIN_BITS;
  localparam int ADD_BITS       = FIELD_BITS + 2;

  localparam logic [FIELD_BITS-1:0] SAMPLE_MASK =
    FIELD_BITS'((33'd1 << SAMPLE_BITS) - 33'd1);
  localparam logic [PROD_BITS:0] ROUND_HALF = (PROD_BITS + 1)'(1) << (FRAC_BITS - 1);

  typedef logic [MODE_BITS-1:0] mode_t;

  localparam mode_t MODE_MUL   = 4'd0;
  localparam mode_t MODE_DIV   = 4'd1;
  localparam mode_t MODE_ADD   = 4'd2;
  localparam mode_t MODE_SUB   = 4'd3;
  localparam mode_t MODE_FLOOR = 4'd4;
  localparam mode_t MODE_CEIL  = 4'd5;
  localparam mode_t MODE_AND   = 4'd6;
  localparam mode_t MODE_OR    = 4'd7;
  localparam mode_t MODE_XOR   = 4'd8;
  localparam mode_t MODE_NOT   = 4'd9;
  localparam mode_t MODE_SHL   = 4'd10;
  localparam mode_t MODE_SHR   = 4'd11;

  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

  localparam cfg_index_t CFG_MODE    = 3'd0;
  localparam cfg_index_t CFG_GAIN    = 3'd1;
  localparam cfg_index_t CFG_OFFSET  = 3'd2;
  localparam cfg_index_t CFG_OPERAND = 3'd3;
  localparam cfg_index_t CFG_SHIFT   = 3'd4;
  localparam cfg_index_t CFG_MAXVAL  = 3'd5;

  localparam logic [GAIN_BITS-1:0]  GAIN_RESET   = 32'd65536;
  localparam logic [FIELD_BITS-1:0] MAXVAL_RESET = 16'd255;

endpackage

// File: hw/rtl/pixel_point_function_unit_core.sv
// Top level of the pixel point-function unit: config registers and a three-stage pipeline.
//
// Input stream (in_*): one sample per request, in_tdata carries the sample and
// in_tlast marks the last sample of a row. Output stream (out_*): the function
// result clamped to maxval, with in_tlast copied to out_tlast.
// Configuration: cfg_wr_en writes cfg_wdata into register cfg_index
// (0 mode, 1 gain, 2 offset, 3 operand, 4 shift_count, 5 maxval); write only
// while the pipeline is empty.
// A request passes the input register, the product/function register and the
// clamp register, in that order, before it shows on out_*.
// Throughput: one sample per cycle while out_tready is high; the stage-two 16x32
// multiply and the stage-three round-and-clamp compare set the clock period.
// Reset (rst_n low, synchronous) empties all stages and restores register
// defaults (gain 1.0, maxval 255, others 0).
// When out_tready is low, the result holds on out_*; the two stages behind it
// keep filling, so up to three requests are held before in_tready drops.
module pixel_point_function_unit_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [ppfu_pkg::TDATA_BITS-1:0]       in_tdata,   // [15:0] sample_in
  input  logic                                  in_tlast,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [ppfu_pkg::TDATA_BITS-1:0]       out_tdata,  // [15:0] sample_out
  output logic                                  out_tlast,
  input  logic                                  cfg_wr_en,
  input  logic [ppfu_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [ppfu_pkg::CFG_DATA_BITS-1:0]    cfg_wdata
);

  localparam int FB = ppfu_pkg::FIELD_BITS;
  localparam int PB = ppfu_pkg::PROD_BITS;
  localparam int AB = ppfu_pkg::ADD_BITS;
  localparam int OB = ppfu_pkg::OFFSET_BITS;

  ppfu_pkg::mode_t                        mode_r;
  logic [ppfu_pkg::GAIN_BITS-1:0]         gain_r;
  logic signed [OB-1:0]                   offset_r;
  logic [FB-1:0]                          operand_r;
  logic [ppfu_pkg::SHIFT_BITS-1:0]        shift_r;
  logic [FB-1:0]                          maxval_r;

  logic                                   s1_valid_r;
  logic [FB-1:0]                          s1_sample_r;
  logic                                   s1_last_r;
  logic                                   s2_valid_r;
  logic [PB-1:0]                          s2_raw_r;
  logic                                   s2_mul_r;
  logic                                   s2_last_r;
  logic                                   out_valid_r;
  logic [FB-1:0]                          out_sample_r;
  logic                                   out_last_r;

  logic                                   out_open;
  logic                                   s2_open;
  logic                                   s1_open;
  logic                                   in_fire;
  logic [FB-1:0]                          mv;
  logic signed [AB-1:0]                   off_ext;
  logic signed [AB-1:0]                   sum;
  logic [AB-2:0]                          sum_sat;
  logic [FB-1:0]                          func;
  logic [PB-1:0]                          s2_raw_nxt;
  logic                                   s2_mul_nxt;
  logic [PB:0]                            rounded;
  logic [PB-1:0]                          cand;
  logic [FB-1:0]                          out_sample_nxt;

  assign out_open  = !out_valid_r || out_tready;
  assign s2_open   = !s2_valid_r || out_open;
  assign s1_open   = !s1_valid_r || s2_open;
  assign in_tready = s1_open;
  assign in_fire   = in_tvalid && s1_open;

  assign mv = maxval_r & ppfu_pkg::SAMPLE_MASK;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= ppfu_pkg::MODE_MUL;
      gain_r    <= ppfu_pkg::GAIN_RESET;
      offset_r  <= '0;
      operand_r <= '0;
      shift_r   <= '0;
      maxval_r  <= ppfu_pkg::MAXVAL_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        ppfu_pkg::CFG_MODE:    mode_r    <= cfg_wdata[ppfu_pkg::MODE_BITS-1:0];
        ppfu_pkg::CFG_GAIN:    gain_r    <= cfg_wdata[ppfu_pkg::GAIN_BITS-1:0];
        ppfu_pkg::CFG_OFFSET:  offset_r  <= $signed(cfg_wdata[OB-1:0]);
        ppfu_pkg::CFG_OPERAND: operand_r <= cfg_wdata[FB-1:0];
        ppfu_pkg::CFG_SHIFT:   shift_r   <= cfg_wdata[ppfu_pkg::SHIFT_BITS-1:0];
        ppfu_pkg::CFG_MAXVAL:  maxval_r  <= cfg_wdata[FB-1:0];
        default: ;
      endcase
    end
  end

  // Stage two: function of the held sample
  always_comb begin
    off_ext    = {{(AB-OB){offset_r[OB-1]}}, offset_r};
    sum        = '0;
    sum_sat    = '0;
    func       = s1_sample_r;
    s2_mul_nxt = 1'b0;
    case (mode_r) inside
      ppfu_pkg::MODE_ADD, ppfu_pkg::MODE_SUB: begin
        if (mode_r == ppfu_pkg::MODE_ADD) begin
          sum = $signed({2'b00, s1_sample_r}) + off_ext;
        end else begin
          sum = $signed({2'b00, s1_sample_r}) - off_ext;
        end
        sum_sat = sum[AB-1] ? '0 : sum[AB-2:0];
      end
      default: ;
    endcase
    case (mode_r)
      ppfu_pkg::MODE_MUL, ppfu_pkg::MODE_DIV: s2_mul_nxt = 1'b1;
      ppfu_pkg::MODE_FLOOR: func = (s1_sample_r < operand_r) ? s1_sample_r : operand_r;
      ppfu_pkg::MODE_CEIL:  func = (s1_sample_r > operand_r) ? s1_sample_r : operand_r;
      ppfu_pkg::MODE_AND:   func = s1_sample_r & operand_r;
      ppfu_pkg::MODE_OR:    func = s1_sample_r | operand_r;
      ppfu_pkg::MODE_XOR:   func = s1_sample_r ^ operand_r;
      ppfu_pkg::MODE_NOT:   func = mv ^ s1_sample_r;
      ppfu_pkg::MODE_SHL:   func = (s1_sample_r << shift_r) & mv;
      ppfu_pkg::MODE_SHR:   func = s1_sample_r >> shift_r;
      default:              func = s1_sample_r;
    endcase
    if (s2_mul_nxt) begin
      s2_raw_nxt = PB'(s1_sample_r) * PB'(gain_r);
    end else if (mode_r == ppfu_pkg::MODE_ADD || mode_r == ppfu_pkg::MODE_SUB) begin
      s2_raw_nxt = PB'(sum_sat);
    end else begin
      s2_raw_nxt = PB'(func);
    end
  end

  // Stage three: round products, clamp to maxval
  always_comb begin
    rounded = ({1'b0, s2_raw_r} + ppfu_pkg::ROUND_HALF) >> ppfu_pkg::FRAC_BITS;
    cand    = s2_mul_r ? rounded[PB-1:0] : s2_raw_r;
    out_sample_nxt = (cand > PB'(mv)) ? mv : cand[FB-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_open) begin
        s1_valid_r <= in_tvalid;
      end
      if (s2_open) begin
        s2_valid_r <= s1_valid_r;
      end
      if (out_open) begin
        out_valid_r <= s2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_sample_r <= in_tdata[FB-1:0] & ppfu_pkg::SAMPLE_MASK;
      s1_last_r   <= in_tlast;
    end
    if (s2_open && s1_valid_r) begin
      s2_raw_r  <= s2_raw_nxt;
      s2_mul_r  <= s2_mul_nxt;
      s2_last_r <= s1_last_r;
    end
    if (out_open && s2_valid_r) begin
      out_sample_r <= out_sample_nxt;
      out_last_r   <= s2_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = ppfu_pkg::TDATA_BITS'(out_sample_r);
  assign out_tlast  = out_last_r;

endmodule

// File: hw/rtl/ppfu_checker.sv
// Port-level checker for the pixel point-function unit, bound to the top level.
`include "pixel_point_function_unit_core_defines.svh"

module ppfu_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_tvalid,
  input logic                                 in_tready,
  input logic                                 out_tvalid,
  input logic                                 out_tready,
  input logic [ppfu_pkg::TDATA_BITS-1:0]      out_tdata,  // [15:0] sample_out
  input logic                                 out_tlast
);

  `PPFU_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled result changed")
  `PPFU_ASSERT_RESET(a_reset_empty, !rst_n, in_tready && !out_tvalid, "pipeline not empty after reset")
  `PPFU_ASSERT_NOW(a_out_from_request, $rose(out_tvalid), $past(in_tvalid && in_tready, 3), "result without request three cycles earlier")

endmodule

bind pixel_point_function_unit_core ppfu_checker u_ppfu_checker (.*);

// File: tb/tb.sv
// Self-checking stream testbench for the pixel point-function unit core.
`timescale 1ns / 100ps

module tb;
  import ppfu_pkg::*;

  localparam mode_t MODE_SPARE_LO = 4'd12;
  localparam mode_t MODE_SPARE_HI = 4'd15;
  localparam int    CYCLE_LIMIT   = 200000;
  localparam int    RANDOM_ITEMS  = 950;
  localparam int    PIPE_CYCLES   = 4;

  typedef struct {
    logic [SAMPLE_BITS-1:0] value;
    logic                   row_end;
  } pix_t;

  logic                      clk;
  logic                      rst_n      = 1'b0;
  logic                      in_tvalid  = 1'b0;
  logic                      in_tready;
  logic [TDATA_BITS-1:0]     in_tdata   = '0;
  logic                      in_tlast   = 1'b0;
  logic                      out_tvalid;
  logic                      out_tready = 1'b1;
  logic [TDATA_BITS-1:0]     out_tdata;
  logic                      out_tlast;
  logic                      cfg_wr_en  = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index  = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_wdata  = '0;

  mode_t                  rg_mode    = MODE_MUL;
  logic [GAIN_BITS-1:0]   rg_gain    = GAIN_RESET;
  logic [OFFSET_BITS-1:0] rg_offset  = '0;
  logic [FIELD_BITS-1:0]  rg_operand = '0;
  logic [SHIFT_BITS-1:0]  rg_shift   = '0;
  logic [FIELD_BITS-1:0]  rg_maxval  = MAXVAL_RESET;

  pix_t pending_pix[$];
  pix_t expected_pix[$];
  int   items_loaded = 0;
  int   results_seen = 0;
  int   err_count    = 0;
  int   settings     = 0;
  int   long_holds   = 0;
  int   hold_at      = -1;
  int   cycle_count  = 0;
  int   burst_left   = 0;
  int   gap_left     = 0;
  int   hold_left    = 0;
  int   window_left  = 0;
  int   ready_mode   = 0;

  pixel_point_function_unit_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [SAMPLE_BITS-1:0] point_result(input logic [SAMPLE_BITS-1:0] s);
    logic [63:0] r;
    logic [18:0] t;
    logic [18:0] off_x;
    off_x = {{2{rg_offset[OFFSET_BITS-1]}}, rg_offset};
    case (rg_mode)
      MODE_MUL, MODE_DIV: r = ({48'd0, s} * {32'd0, rg_gain} + 64'h8000) >> FRAC_BITS;
      MODE_ADD, MODE_SUB: begin
        t = (rg_mode == MODE_ADD) ? {3'b000, s} + off_x : {3'b000, s} - off_x;
        r = t[18] ? 64'd0 : {45'd0, t};
      end
      MODE_FLOOR: r = (s < rg_operand) ? {48'd0, s} : {48'd0, rg_operand};
      MODE_CEIL:  r = (s > rg_operand) ? {48'd0, s} : {48'd0, rg_operand};
      MODE_AND:   r = {48'd0, s & rg_operand};
      MODE_OR:    r = {48'd0, s | rg_operand};
      MODE_XOR:   r = {48'd0, s ^ rg_operand};
      MODE_NOT:   r = {48'd0, rg_maxval ^ s};
      MODE_SHL:   r = ({48'd0, s} << rg_shift) & {48'd0, rg_maxval};
      MODE_SHR:   r = {48'd0, s} >> rg_shift;
      default:    r = {48'd0, s};
    endcase
    if (r > {48'd0, rg_maxval}) r = {48'd0, rg_maxval};
    return r[SAMPLE_BITS-1:0];
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return '1;
      1:       return '0;
      2:       return rg_maxval;
      3:       return SAMPLE_BITS'($urandom);
      default: return SAMPLE_BITS'($urandom_range(0, rg_maxval));
    endcase
  endfunction

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_BITS-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_MODE:    rg_mode    = val[MODE_BITS-1:0];
      CFG_GAIN:    rg_gain    = val[GAIN_BITS-1:0];
      CFG_OFFSET:  rg_offset  = val[OFFSET_BITS-1:0];
      CFG_OPERAND: rg_operand = val[FIELD_BITS-1:0];
      CFG_SHIFT:   rg_shift   = val[SHIFT_BITS-1:0];
      CFG_MAXVAL:  rg_maxval  = val[FIELD_BITS-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_config(input mode_t m, input logic [GAIN_BITS-1:0] g,
                            input logic [OFFSET_BITS-1:0] off, input logic [FIELD_BITS-1:0] opnd,
                            input logic [SHIFT_BITS-1:0] sh, input logic [FIELD_BITS-1:0] mv);
    write_reg(CFG_MODE, CFG_DATA_BITS'(m));
    write_reg(CFG_GAIN, g);
    write_reg(CFG_OFFSET, {{(CFG_DATA_BITS-OFFSET_BITS){off[OFFSET_BITS-1]}}, off});
    write_reg(CFG_OPERAND, CFG_DATA_BITS'(opnd));
    write_reg(CFG_SHIFT, CFG_DATA_BITS'(sh));
    write_reg(CFG_MAXVAL, CFG_DATA_BITS'(mv));
    settings++;
  endtask

  task automatic load_pix(input logic [SAMPLE_BITS-1:0] s, input logic l);
    pix_t p;
    p.value   = s;
    p.row_end = l;
    pending_pix.push_back(p);
    items_loaded++;
  endtask

  task automatic drain();
    while (results_seen < items_loaded) @(posedge clk);
    repeat (PIPE_CYCLES) @(posedge clk);
  endtask

  // request driver: bursts with random gaps
  always @(posedge clk) begin
    pix_t nxt;
    pix_t exp_pix;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        exp_pix.value   = point_result(in_tdata[SAMPLE_BITS-1:0]);
        exp_pix.row_end = in_tlast;
        expected_pix.push_back(exp_pix);
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0 || pending_pix.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_tvalid <= 1'b0;
        end else begin
          nxt = pending_pix.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= TDATA_BITS'(nxt.value);
          in_tlast  <= nxt.row_end;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
          end
        end
      end
    end
  end

  // result monitor and output stall pattern
  always @(posedge clk) begin
    pix_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (expected_pix.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result sample=%h last=%b", $time,
                   out_tdata[SAMPLE_BITS-1:0], out_tlast);
        end else begin
          want = expected_pix.pop_front();
          if (out_tdata[SAMPLE_BITS-1:0] !== want.value) begin
            err_count++;
            $display("%0t: sample_out expected %h actual %h", $time, want.value,
                     out_tdata[SAMPLE_BITS-1:0]);
          end
          if (out_tlast !== want.row_end) begin
            err_count++;
            $display("%0t: last_out expected %b actual %b", $time, want.row_end, out_tlast);
          end
        end
        if (results_seen == hold_at) begin
          hold_left = $urandom_range(40, 80);
          long_holds++;
        end
      end
      if (window_left == 0) begin
        window_left = 64;
        ready_mode  = $urandom_range(0, 3);
      end else begin
        window_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        case (ready_mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= $urandom_range(0, 1) == 1;
          2:       out_tready <= $urandom_range(0, 7) != 0;
          default: out_tready <= window_left[2];
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** pixel_point_function_unit_core: FAILED **");
      $finish;
    end
  end

  initial begin
    int             rand_items;
    int             n;
    mode_t          m;
    logic [31:0]    g;
    logic [16:0]    off;
    logic [15:0]    opnd;
    logic [4:0]     sh;
    logic [15:0]    mv;
    rand_items = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    load_pix(16'h0000, 1'b0);
    load_pix(16'h00FF, 1'b0);
    load_pix(16'hFFFF, 1'b1);
    drain();
    set_config(MODE_MUL, 32'h0001_8000, '0, '0, '0, 16'hFFFF);
    load_pix(16'h0001, 1'b0);
    load_pix(16'hFFFF, 1'b1);
    drain();
    set_config(MODE_MUL, 32'hFFFF_FFFF, '0, '0, '0, 16'hFFFF);
    load_pix(16'hFFFF, 1'b1);
    load_pix(16'h0000, 1'b0);
    drain();
    set_config(MODE_DIV, 32'h0000_5555, '0, '0, '0, 16'hFFFF);
    load_pix(16'hFFFF, 1'b0);
    load_pix(16'h0003, 1'b1);
    drain();
    set_config(MODE_ADD, GAIN_RESET, 17'h0_FFFF, '0, '0, 16'hFFFF);
    load_pix(16'hFFFF, 1'b0);
    load_pix(16'h0000, 1'b1);
    drain();
    set_config(MODE_SUB, GAIN_RESET, 17'h0_FFFF, '0, '0, 16'hFFFF);
    load_pix(16'h0000, 1'b1);
    load_pix(16'hFFFF, 1'b0);
    drain();
    set_config(MODE_ADD, GAIN_RESET, 17'h1_0000, '0, '0, 16'hFFFF);
    load_pix(16'h0001, 1'b0);
    drain();
    set_config(MODE_FLOOR, GAIN_RESET, '0, 16'd100, '0, 16'd255);
    load_pix(16'd99, 1'b0);
    load_pix(16'd101, 1'b1);
    drain();
    set_config(MODE_CEIL, GAIN_RESET, '0, 16'd100, '0, 16'd255);
    load_pix(16'd99, 1'b0);
    drain();
    set_config(MODE_AND, GAIN_RESET, '0, 16'hA5A5, '0, 16'hFFFF);
    load_pix(16'hFFFF, 1'b1);
    drain();
    set_config(MODE_OR, GAIN_RESET, '0, 16'hA5A5, '0, 16'hFFFF);
    load_pix(16'h5A5A, 1'b0);
    drain();
    set_config(MODE_XOR, GAIN_RESET, '0, 16'hA5A5, '0, 16'hFFFF);
    load_pix(16'hFFFF, 1'b0);
    drain();
    set_config(MODE_NOT, GAIN_RESET, '0, '0, '0, 16'd1000);
    load_pix(16'd5, 1'b1);
    drain();
    set_config(MODE_SHL, GAIN_RESET, '0, '0, 5'd31, 16'hFFFF);
    load_pix(16'hFFFF, 1'b0);
    drain();
    set_config(MODE_SHL, GAIN_RESET, '0, '0, 5'd4, 16'h0FFF);
    load_pix(16'h0123, 1'b1);
    drain();
    set_config(MODE_SHR, GAIN_RESET, '0, '0, 5'd16, 16'hFFFF);
    load_pix(16'hFFFF, 1'b0);
    drain();
    set_config(MODE_SHR, GAIN_RESET, '0, '0, 5'd31, 16'hFFFF);
    load_pix(16'h8000, 1'b1);
    drain();
    set_config(MODE_SPARE_HI, GAIN_RESET, '0, '0, '0, 16'h8000);
    load_pix(16'hFFFF, 1'b0);
    drain();
    set_config(MODE_MUL, GAIN_RESET, '0, '0, '0, 16'h0000);
    load_pix(16'hFFFF, 1'b1);
    drain();

    while (rand_items < RANDOM_ITEMS) begin
      m = mode_t'($urandom_range(0, 12));
      if (m == MODE_SPARE_LO) m = mode_t'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
      case ($urandom_range(0, 5))
        0:       g = 32'h0000_0000;
        1:       g = 32'hFFFF_FFFF;
        2:       g = GAIN_RESET;
        3:       g = $urandom_range(0, 131071);
        4:       g = $urandom_range(1, 65536);
        default: g = $urandom;
      endcase
      case ($urandom_range(0, 5))
        0:       off = 17'h1_0000;
        1:       off = 17'h1_0001;
        2:       off = 17'h0_FFFF;
        3:       off = '0;
        default: off = 17'($urandom);
      endcase
      case ($urandom_range(0, 4))
        0:       opnd = '0;
        1:       opnd = '1;
        default: opnd = 16'($urandom);
      endcase
      case ($urandom_range(0, 4))
        0:       sh = '0;
        1:       sh = 5'd16;
        2:       sh = 5'd31;
        default: sh = 5'($urandom_range(0, 17));
      endcase
      case ($urandom_range(0, 7))
        0:       mv = 16'h0000;
        1:       mv = 16'h0001;
        2:       mv = 16'hFFFF;
        3:       mv = 16'h00FF;
        default: mv = 16'($urandom_range(1, 65535));
      endcase
      set_config(m, g, off, opnd, sh, mv);
      n = $urandom_range(8, 40);
      if (rand_items < 60 && rand_items + n >= 60 || rand_items >= 500 && hold_at < 100) begin
        n = 160;
        hold_at <= results_seen + 40;
      end
      repeat (n) load_pix(pick_sample(), $urandom_range(0, 7) == 0);
      rand_items += n;
      drain();
    end

    $display("Checked %0d samples under %0d register settings: all functions, spare codes,",
             results_seen, settings);
    $display("maxval from 0 to full scale, shifts to 31, %0d long output stalls.", long_holds);
    if (err_count == 0 && expected_pix.size() == 0) begin
      $display("** pixel_point_function_unit_core: PASSED **");
    end else begin
      $display("** pixel_point_function_unit_core: FAILED **");
    end
    $finish;
  end

endmodule
